// ===== hw/rtl/sgi_pkg.sv =====
// ---------------------------------------------------------------------------
// sgi_pkg: shared types and constants of the segment intersection unit
// Widths of the datapath, outcome codes and the structs that flow down the
// divider chain.
// ---------------------------------------------------------------------------
package sgi_pkg;

  localparam int CW    = 16;          // coordinate width
  localparam int DW    = CW + 1;      // coordinate difference
  localparam int PW    = 2 * CW + 2;  // product of two differences
  localparam int SW    = 2 * CW + 3;  // side value
  localparam int DENW  = 2 * CW + 4;  // determinant, divisor, dividend
  localparam int RW    = 2 * CW + 5;  // divider remainder with headroom
  localparam int QW    = CW + 2;      // quotient
  localparam int MW    = CW + 2;      // multiplicand magnitude
  localparam int IPW   = CW + 3;      // unsaturated integer point
  localparam int STEPS = CW + 2;      // divider cells

  localparam logic [1:0] OUTCOME_NONE      = 2'd0;
  localparam logic [1:0] OUTCOME_HIT       = 2'd1;
  localparam logic [1:0] OUTCOME_COLLINEAR = 2'd2;

  typedef struct packed {
    logic [QW-1:0] q;
    logic [RW-1:0] r;
    logic [MW-1:0] mag;
  } lane_t;

  typedef struct packed {
    logic [DENW-1:0]       td;
    logic [DENW-1:0]       tn;
    logic [1:0]            outcome;
    logic signed [CW-1:0]  base_x;
    logic signed [CW-1:0]  base_y;
    logic                  neg_x;
    logic                  neg_y;
  } ctl_t;

endpackage

// ===== hw/rtl/segment_intersection_unit.sv =====
// ---------------------------------------------------------------------------
// segment_intersection_unit: pipelined 2D segment pair intersection
// Side tests, determinant and a chain of division cells that give the
// rounded crossing point of two integer segments.
// ---------------------------------------------------------------------------
// Usage. A request on the in_ channel carries two segments, first (start to
// end) and second, as signed 16-bit endpoints. For each request the out_
// channel returns one result: out_outcome is 0 when one segment lies
// strictly on one side of the other's line, otherwise 2 when the
// determinant is zero (collinear or degenerate), and 1 when the segments
// cross, in which case out_cross_x and out_cross_y hold the crossing point
// rounded to the nearest integer, halves away from zero. For the other
// outcomes both coordinates are zero.
// Throughput is one request per cycle while the output is not stalled. The
// pipeline runs through stages of differences and products, side values,
// determinant and divisor setup, eighteen division cells (one quotient bit
// each), one rounding stage and the output register. The whole pipeline
// advances together whenever the output register is empty or being drained,
// so in_ready follows out_ready while a result is held; a stalled result
// keeps its value. Reset (rst_n low at a clock edge) clears all valid flags;
// no request is lost or duplicated across a stall.
// ---------------------------------------------------------------------------
module segment_intersection_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [sgi_pkg::CW-1:0] in_first_start_x,
  input  logic signed [sgi_pkg::CW-1:0] in_first_start_y,
  input  logic signed [sgi_pkg::CW-1:0] in_first_end_x,
  input  logic signed [sgi_pkg::CW-1:0] in_first_end_y,
  input  logic signed [sgi_pkg::CW-1:0] in_second_start_x,
  input  logic signed [sgi_pkg::CW-1:0] in_second_start_y,
  input  logic signed [sgi_pkg::CW-1:0] in_second_end_x,
  input  logic signed [sgi_pkg::CW-1:0] in_second_end_y,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_outcome,
  output logic signed [sgi_pkg::CW-1:0] out_cross_x,
  output logic signed [sgi_pkg::CW-1:0] out_cross_y
);

  localparam int CW    = sgi_pkg::CW;
  localparam int DW    = sgi_pkg::DW;
  localparam int PW    = sgi_pkg::PW;
  localparam int SW    = sgi_pkg::SW;
  localparam int DENW  = sgi_pkg::DENW;
  localparam int MW    = sgi_pkg::MW;
  localparam int STEPS = sgi_pkg::STEPS;
  localparam int NV    = STEPS + 5;  // valid flags from stage 1 to rounding

  function automatic logic signed [DW-1:0] sub(logic signed [CW-1:0] a,
                                               logic signed [CW-1:0] b);
    return DW'(a) - DW'(b);
  endfunction

  function automatic logic signed [PW-1:0] mul(logic signed [DW-1:0] a,
                                               logic signed [DW-1:0] b);
    return PW'(a) * PW'(b);
  endfunction

  // Strictly on the same side: both nonzero with equal signs.
  function automatic logic same_side(logic signed [SW-1:0] a,
                                     logic signed [SW-1:0] b);
    return (a != '0) && (b != '0) && (a[SW-1] == b[SW-1]);
  endfunction

  logic en;
  logic [NV-1:0] vld_r;
  logic          out_valid_r;

  // The pipeline moves as a whole whenever the output register can load.
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NV-2:0], in_valid};
      out_valid_r <= vld_r[NV-1];
    end
  end

  // Stage 1: edge vectors and the eight products of the side tests.
  logic signed [DW-1:0] dx1, dy1, dx3, dy3;
  logic signed [PW-1:0] p_nxt [8];
  logic signed [PW-1:0] p_r   [8];
  logic signed [CW-1:0] bx1_r, by1_r;
  logic signed [DW-1:0] dx1_r, dy1_r;

  assign dx1 = sub(in_first_end_x, in_first_start_x);
  assign dy1 = sub(in_first_end_y, in_first_start_y);
  assign dx3 = sub(in_second_end_x, in_second_start_x);
  assign dy3 = sub(in_second_end_y, in_second_start_y);

  // Side of the second segment's endpoints against the first line.
  assign p_nxt[0] = mul(dy1, sub(in_second_start_x, in_first_start_x));
  assign p_nxt[1] = mul(dx1, sub(in_second_start_y, in_first_start_y));
  assign p_nxt[2] = mul(dy1, sub(in_second_end_x, in_first_start_x));
  assign p_nxt[3] = mul(dx1, sub(in_second_end_y, in_first_start_y));
  // Side of the first segment's endpoints against the second line.
  assign p_nxt[4] = mul(dy3, sub(in_first_start_x, in_second_start_x));
  assign p_nxt[5] = mul(dx3, sub(in_first_start_y, in_second_start_y));
  assign p_nxt[6] = mul(dy3, sub(in_first_end_x, in_second_start_x));
  assign p_nxt[7] = mul(dx3, sub(in_first_end_y, in_second_start_y));

  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= p_nxt;
      bx1_r <= in_first_start_x;
      by1_r <= in_first_start_y;
      dx1_r <= dx1;
      dy1_r <= dy1;
    end
  end

  // Stage 2: side values.
  logic signed [SW-1:0] s1_2r, s2_2r, s3_2r, s4_2r;
  logic signed [CW-1:0] bx1_2r, by1_2r;
  logic signed [DW-1:0] dx1_2r, dy1_2r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_2r  <= SW'(p_r[0]) - SW'(p_r[1]);
      s4_2r  <= SW'(p_r[2]) - SW'(p_r[3]);
      s1_2r  <= SW'(p_r[4]) - SW'(p_r[5]);
      s2_2r  <= SW'(p_r[6]) - SW'(p_r[7]);
      bx1_2r <= bx1_r;
      by1_2r <= by1_r;
      dx1_2r <= dx1_r;
      dy1_2r <= dy1_r;
    end
  end

  // Stage 3: rejection and determinant.
  logic signed [DENW-1:0] den_3r;
  logic signed [SW-1:0]   s1_3r;
  logic                   rej_3r;
  logic signed [CW-1:0]   bx1_3r, by1_3r;
  logic signed [DW-1:0]   dx1_3r, dy1_3r;

  always_ff @(posedge clk) begin
    if (en) begin
      den_3r <= DENW'(s2_2r) - DENW'(s1_2r);
      s1_3r  <= s1_2r;
      rej_3r <= same_side(s3_2r, s4_2r) || same_side(s1_2r, s2_2r);
      bx1_3r <= bx1_2r;
      by1_3r <= by1_2r;
      dx1_3r <= dx1_2r;
      dy1_3r <= dy1_2r;
    end
  end

  // Stage 4: divisor and dividend of the line parameter, sign normalized
  // and the dividend clamped to [0, divisor].
  logic signed [DENW-1:0] td_s, tn_s, s1_e;
  logic [DENW-1:0]        tn_c;
  logic [1:0]             outcome_nxt;
  sgi_pkg::ctl_t          ctl_c [STEPS+1];
  sgi_pkg::lane_t         lx_c  [STEPS+1];
  sgi_pkg::lane_t         ly_c  [STEPS+1];
  sgi_pkg::ctl_t          ctl_4r;
  sgi_pkg::lane_t         lx_4r, ly_4r;
  logic signed [DW-1:0]   adx, ady;

  assign s1_e = DENW'(s1_3r);
  assign td_s = den_3r[DENW-1] ? -den_3r : den_3r;
  assign tn_s = den_3r[DENW-1] ? s1_e : -s1_e;
  assign adx  = dx1_3r[DW-1] ? -dx1_3r : dx1_3r;
  assign ady  = dy1_3r[DW-1] ? -dy1_3r : dy1_3r;

  always_comb begin
    priority if (tn_s[DENW-1]) begin
      tn_c = '0;
    end else if (tn_s > td_s) begin
      tn_c = td_s;
    end else begin
      tn_c = tn_s;
    end
  end

  always_comb begin
    priority if (rej_3r) begin
      outcome_nxt = sgi_pkg::OUTCOME_NONE;
    end else if (den_3r == '0) begin
      outcome_nxt = sgi_pkg::OUTCOME_COLLINEAR;
    end else begin
      outcome_nxt = sgi_pkg::OUTCOME_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_4r.td      <= td_s;
      ctl_4r.tn      <= tn_c;
      ctl_4r.outcome <= outcome_nxt;
      ctl_4r.base_x  <= bx1_3r;
      ctl_4r.base_y  <= by1_3r;
      ctl_4r.neg_x   <= dx1_3r[DW-1];
      ctl_4r.neg_y   <= dy1_3r[DW-1];
      lx_4r.q        <= '0;
      lx_4r.r        <= '0;
      lx_4r.mag      <= MW'($unsigned(adx));
      ly_4r.q        <= '0;
      ly_4r.r        <= '0;
      ly_4r.mag      <= MW'($unsigned(ady));
    end
  end

  assign ctl_c[0] = ctl_4r;
  assign lx_c[0]  = lx_4r;
  assign ly_c[0]  = ly_4r;

  // Chain of division cells, most significant multiplicand bit first.
  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    sgi_div_cell u_cell (
      .clk     (clk),
      .en      (en),
      .ctl_in  (ctl_c[i]),
      .x_in    (lx_c[i]),
      .y_in    (ly_c[i]),
      .ctl_out (ctl_c[i+1]),
      .x_out   (lx_c[i+1]),
      .y_out   (ly_c[i+1])
    );
  end

  // Rounding: one registered stage in each lane, outcome carried alongside.
  sgi_pkg::ctl_t        ctl_end;
  logic [1:0]           outcome_5r;
  logic signed [CW-1:0] rx, ry;

  assign ctl_end = ctl_c[STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      outcome_5r <= ctl_end.outcome;
    end
  end

  sgi_round u_round_x (
    .clk   (clk),
    .en    (en),
    .base  (ctl_end.base_x),
    .neg   (ctl_end.neg_x),
    .q     (lx_c[STEPS].q),
    .r     (lx_c[STEPS].r),
    .td    (ctl_end.td),
    .coord (rx)
  );

  sgi_round u_round_y (
    .clk   (clk),
    .en    (en),
    .base  (ctl_end.base_y),
    .neg   (ctl_end.neg_y),
    .q     (ly_c[STEPS].q),
    .r     (ly_c[STEPS].r),
    .td    (ctl_end.td),
    .coord (ry)
  );

  // Output register; coordinates are zero unless the segments cross.
  logic [1:0]           out_outcome_r;
  logic signed [CW-1:0] out_cross_x_r, out_cross_y_r;
  logic                 hit;

  assign hit = (outcome_5r == sgi_pkg::OUTCOME_HIT);

  always_ff @(posedge clk) begin
    if (en) begin
      out_outcome_r <= outcome_5r;
      out_cross_x_r <= hit ? rx : '0;
      out_cross_y_r <= hit ? ry : '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_outcome = out_outcome_r;
  assign out_cross_x = out_cross_x_r;
  assign out_cross_y = out_cross_y_r;

endmodule

// ===== hw/rtl/sgi_div_cell.sv =====
// ---------------------------------------------------------------------------
// sgi_div_cell: one step of the scaled division
// Takes one multiplicand bit per lane, folds it into quotient and remainder
// and hands the result to the next cell.
// ---------------------------------------------------------------------------
module sgi_div_cell (
  input  logic           clk,
  input  logic           en,
  input  sgi_pkg::ctl_t  ctl_in,
  input  sgi_pkg::lane_t x_in,
  input  sgi_pkg::lane_t y_in,
  output sgi_pkg::ctl_t  ctl_out,
  output sgi_pkg::lane_t x_out,
  output sgi_pkg::lane_t y_out
);

  function automatic sgi_pkg::lane_t step(sgi_pkg::lane_t l,
                                          logic [sgi_pkg::DENW-1:0] td,
                                          logic [sgi_pkg::DENW-1:0] tn);
    logic [sgi_pkg::RW-1:0] r;
    logic [sgi_pkg::RW-1:0] d;
    logic [sgi_pkg::QW-1:0] q;
    sgi_pkg::lane_t o;
    d = sgi_pkg::RW'(td);
    q = {l.q[sgi_pkg::QW-2:0], 1'b0};
    r = {l.r[sgi_pkg::RW-2:0], 1'b0};
    if (r >= d) begin
      r = r - d;
      q = q + sgi_pkg::QW'(1);
    end
    if (l.mag[sgi_pkg::MW-1]) begin
      r = r + sgi_pkg::RW'(tn);
      if (r >= d) begin
        r = r - d;
        q = q + sgi_pkg::QW'(1);
      end
    end
    o.q   = q;
    o.r   = r;
    o.mag = {l.mag[sgi_pkg::MW-2:0], 1'b0};
    return o;
  endfunction

  sgi_pkg::ctl_t  ctl_r;
  sgi_pkg::lane_t x_r;
  sgi_pkg::lane_t y_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r <= ctl_in;
      x_r   <= step(x_in, ctl_in.td, ctl_in.tn);
      y_r   <= step(y_in, ctl_in.td, ctl_in.tn);
    end
  end

  assign ctl_out = ctl_r;
  assign x_out   = x_r;
  assign y_out   = y_r;

endmodule

// ===== hw/rtl/sgi_round.sv =====
// ---------------------------------------------------------------------------
// sgi_round: rounding and saturation of one coordinate
// Registers the floor of the point and its fraction, then rounds half away
// from zero and clamps to the coordinate range.
// ---------------------------------------------------------------------------
module sgi_round (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [sgi_pkg::CW-1:0] base,
  input  logic                        neg,
  input  logic [sgi_pkg::QW-1:0]      q,
  input  logic [sgi_pkg::RW-1:0]      r,
  input  logic [sgi_pkg::DENW-1:0]    td,
  output logic signed [sgi_pkg::CW-1:0] coord
);

  localparam int IPW = sgi_pkg::IPW;
  localparam int CW  = sgi_pkg::CW;
  localparam logic signed [IPW-1:0] SAT_HI = {{(IPW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [IPW-1:0] SAT_LO = ~SAT_HI;

  logic signed [IPW-1:0]       base_e;
  logic signed [IPW-1:0]       q_e;
  logic signed [IPW-1:0]       ip_nxt;
  logic [sgi_pkg::DENW-1:0]    fr_nxt;
  logic                        r_zero;
  logic signed [IPW-1:0]       ip_r;
  logic [sgi_pkg::DENW-1:0]    fr_r;
  logic [sgi_pkg::DENW-1:0]    td_r;
  logic [sgi_pkg::DENW:0]      fr2;
  logic [sgi_pkg::DENW:0]      td_e;
  logic                        up;
  logic signed [IPW-1:0]       ip_up;

  assign base_e = IPW'(base);
  assign q_e    = $signed({1'b0, q});
  assign r_zero = (r == '0);

  always_comb begin
    if (!neg) begin
      ip_nxt = base_e + q_e;
      fr_nxt = sgi_pkg::DENW'(r);
    end else if (r_zero) begin
      ip_nxt = base_e - q_e;
      fr_nxt = '0;
    end else begin
      ip_nxt = base_e - q_e - IPW'(1);
      fr_nxt = td - sgi_pkg::DENW'(r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ip_r <= ip_nxt;
      fr_r <= fr_nxt;
      td_r <= td;
    end
  end

  // A non-negative floor rounds up on an exact half, a negative one does not.
  assign fr2  = {fr_r, 1'b0};
  assign td_e = {1'b0, td_r};
  assign up   = ip_r[IPW-1] ? (fr2 > td_e) : (fr2 >= td_e);
  assign ip_up = ip_r + $signed({{(IPW-1){1'b0}}, up});

  always_comb begin
    priority if (ip_up > SAT_HI) begin
      coord = SAT_HI[CW-1:0];
    end else if (ip_up < SAT_LO) begin
      coord = SAT_LO[CW-1:0];
    end else begin
      coord = ip_up[CW-1:0];
    end
  end

endmodule
